FILE: rtl/tsd_pkg.sv
// tsd_pkg: shared types, constants and the digit segment table for the
// seven-segment time display unit. No dependencies.
`default_nettype none

package tsd_pkg;

  // register map
  localparam int ADDR_W = 3;
  localparam logic REG_SLZ = 1'b0;  // word index of show_leading_zeros

  // field widths
  localparam int TIME_W = 32;
  localparam int V_W    = 26;  // magnitude after the optional divide by 60
  localparam int HI_W   = 20;  // high part v / 60
  localparam int H100_W = 13;  // hi / 100
  localparam int SEG_W  = 7;
  localparam int DIG_W  = 4;

  // arithmetic constants
  localparam logic [TIME_W-1:0] BIG_LIMIT    = 32'd3600;
  localparam logic [31:0]       DIV60_MAGIC  = 32'h8888_8889;
  localparam logic [31:0]       DIV100_MAGIC = 32'h51EB_851F;
  localparam int                MAGIC_SHIFT  = 37;
  localparam logic [7:0]        DIV10_MAGIC  = 8'd205;
  localparam int                DIV10_SHIFT  = 11;
  localparam logic [HI_W-1:0]   MINUS_LIMIT  = 20'd10;

  // sign and range flags carried down the pipeline
  typedef struct packed {
    logic neg;
    logic big;
    logic phase;
  } tsd_flags_t;

  // quotient stage result
  typedef struct packed {
    logic [V_W-1:0]  v;
    logic [HI_W-1:0] hi;
    tsd_flags_t      flags;
  } tsd_quot_t;

  // decimal digits of the shown value
  typedef struct packed {
    logic [DIG_W-1:0] thousands;
    logic [DIG_W-1:0] hundreds;
    logic [DIG_W-1:0] tens;
    logic [DIG_W-1:0] ones;
    logic             hi_lt10;
    tsd_flags_t       flags;
  } tsd_dig_t;

  // segment pattern for one decimal digit, bit6 top down to bit0 middle
  function automatic logic [SEG_W-1:0] seg7(input logic [DIG_W-1:0] d);
    logic [SEG_W-1:0] s;
    unique case (d)
      4'd0:    s = 7'h7E;
      4'd1:    s = 7'h30;
      4'd2:    s = 7'h6D;
      4'd3:    s = 7'h79;
      4'd4:    s = 7'h33;
      4'd5:    s = 7'h5B;
      4'd6:    s = 7'h5F;
      4'd7:    s = 7'h70;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h7B;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/time_to_seven_segment_display_unit.sv
// channel   dir  width  content
// s_axis    in   32     time_value, signed seconds
// m_axis    out  32     four digit segment patterns, dots, minus bar
// apb       in   3      show_leading_zeros at byte address 0
//
// One item per cycle sustained while m_tready stays high; an item goes
// through six register stages. Two reciprocal multiplies by 1/60, one by
// 1/100 and the split by ten set the stage count.
// rst is synchronous and clears the stage valids, blink phase and register.
// A stalled output holds the last stage; empty stages ahead still fill.
// Top level: uses tsd_pkg, tsd_cfg, tsd_div, tsd_bcd and tsd_seg.
`default_nettype none

module time_to_seven_segment_display_unit (
  input  wire logic                       clk,
  input  wire logic                       rst,
  // time_value [31:0]
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  input  wire logic [31:0]                s_tdata,
  // digit_thousands [6:0], digit_hundreds [13:7], digit_tens [20:14],
  // digit_ones [27:21], lower_dot [28], upper_dot [29], minus_sign [30]
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  output logic [31:0]                     m_tdata,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [tsd_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output logic                            pready
);

  logic               show_leading_zeros;
  logic               blink_phase;
  logic               s_acc;
  logic               quot_valid, quot_ready;
  tsd_pkg::tsd_quot_t quot;
  logic               dig_valid, dig_ready;
  tsd_pkg::tsd_dig_t  dig;

  assign s_acc = s_tvalid && s_tready;

  // blink phase toggles on every accepted negative item
  always_ff @(posedge clk) begin
    if (rst) begin
      blink_phase <= 1'b0;
    end else if (s_acc && s_tdata[31]) begin
      blink_phase <= !blink_phase;
    end
  end

  tsd_cfg u_cfg (
    .clk                (clk),
    .rst                (rst),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .show_leading_zeros (show_leading_zeros)
  );

  tsd_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_raw    (s_tdata),
    .in_phase  (blink_phase),
    .out_valid (quot_valid),
    .out_ready (quot_ready),
    .out_quot  (quot)
  );

  tsd_bcd u_bcd (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (quot_valid),
    .in_ready  (quot_ready),
    .in_quot   (quot),
    .out_valid (dig_valid),
    .out_ready (dig_ready),
    .out_dig   (dig)
  );

  tsd_seg u_seg (
    .clk                (clk),
    .rst                (rst),
    .show_leading_zeros (show_leading_zeros),
    .in_valid           (dig_valid),
    .in_ready           (dig_ready),
    .in_dig             (dig),
    .m_tvalid           (m_tvalid),
    .m_tready           (m_tready),
    .m_tdata            (m_tdata)
  );

  // negative item flips the blink phase
  a_blink_toggle: assert property (@(posedge clk) disable iff (rst)
    s_acc && s_tdata[31] |=> blink_phase != $past(blink_phase))
    else $error("blink phase did not toggle on negative item");

  // non-negative item leaves the blink phase alone
  a_blink_hold: assert property (@(posedge clk) disable iff (rst)
    s_acc && !s_tdata[31] |=> $stable(blink_phase))
    else $error("blink phase changed on non-negative item");

  // a minus bar comes only with a negative value, which lights exactly one dot
  a_minus_dot: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[30] |-> (m_tdata[28] ^ m_tdata[29]))
    else $error("minus bar without a single blinking dot");

  // the rightmost digit is never blank
  a_ones_lit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[27:21] != 7'd0)
    else $error("ones digit blank");

endmodule

`default_nettype wire

FILE: rtl/tsd_cfg.sv
// tsd_cfg: APB-style register for show_leading_zeros.
// Uses tsd_pkg for the address width and register index.
`default_nettype none

module tsd_cfg (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [tsd_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output logic                            pready,
  output logic                            show_leading_zeros
);

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  // register write
  always_ff @(posedge clk) begin
    if (rst) begin
      show_leading_zeros <= 1'b0;
    end else if (wr && (paddr[2] == tsd_pkg::REG_SLZ)) begin
      show_leading_zeros <= pwdata[0];
    end
  end

  // read back
  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == tsd_pkg::REG_SLZ) begin
      prdata = {31'd0, show_leading_zeros};
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tsd_div.sv
// tsd_div: magnitude, optional divide by 60 and split v / 60, three stages
// with reciprocal multiplies. Uses tsd_pkg types and constants.
`default_nettype none

module tsd_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [tsd_pkg::TIME_W-1:0] in_raw,
  input  wire logic                       in_phase,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output tsd_pkg::tsd_quot_t              out_quot
);

  logic                       vld0, vld1, vld2;
  logic                       ld0, ld1, ld2;
  logic [tsd_pkg::TIME_W-1:0] raw0;
  logic                       phase0;
  logic [tsd_pkg::TIME_W-1:0] mag;
  logic [63:0]                prod1;
  logic [tsd_pkg::V_W-1:0]    q1;
  logic [tsd_pkg::V_W-1:0]    mag1;
  tsd_pkg::tsd_flags_t        flags1;
  logic [tsd_pkg::V_W-1:0]    v_next;
  logic [63:0]                prod2;
  tsd_pkg::tsd_quot_t         quot2;

  // stall chain, a stage loads when empty or when its successor moves
  assign ld2      = !vld2 || out_ready;
  assign ld1      = !vld1 || ld2;
  assign ld0      = !vld0 || ld1;
  assign in_ready = ld0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld0 <= 1'b0;
      vld1 <= 1'b0;
      vld2 <= 1'b0;
    end else begin
      if (ld0) vld0 <= in_valid;
      if (ld1) vld1 <= vld0;
      if (ld2) vld2 <= vld1;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (ld0) begin
      raw0   <= in_raw;
      phase0 <= in_phase;
    end
  end

  // magnitude and first reciprocal multiply
  assign mag   = raw0[tsd_pkg::TIME_W-1] ? (32'd0 - raw0) : raw0;
  assign prod1 = {32'd0, mag} * {32'd0, tsd_pkg::DIV60_MAGIC};

  always_ff @(posedge clk) begin
    if (ld1) begin
      q1           <= prod1[tsd_pkg::MAGIC_SHIFT +: tsd_pkg::V_W];
      mag1         <= mag[tsd_pkg::V_W-1:0];
      flags1.neg   <= raw0[tsd_pkg::TIME_W-1];
      flags1.big   <= mag > tsd_pkg::BIG_LIMIT;
      flags1.phase <= phase0;
    end
  end

  // select hours:minutes or minutes:seconds scale, then split into v / 60
  assign v_next = flags1.big ? q1 : mag1;
  assign prod2  = {38'd0, v_next} * {32'd0, tsd_pkg::DIV60_MAGIC};

  always_ff @(posedge clk) begin
    if (ld2) begin
      quot2.v     <= v_next;
      quot2.hi    <= prod2[tsd_pkg::MAGIC_SHIFT +: tsd_pkg::HI_W];
      quot2.flags <= flags1;
    end
  end

  assign out_valid = vld2;
  assign out_quot  = quot2;

endmodule

`default_nettype wire

FILE: rtl/tsd_bcd.sv
// tsd_bcd: low part, hi mod 100 and the four decimal digits, two stages.
// Uses tsd_pkg types and constants.
`default_nettype none

module tsd_bcd (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire tsd_pkg::tsd_quot_t in_quot,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output tsd_pkg::tsd_dig_t       out_dig
);

  logic                        vld0, vld1;
  logic                        ld0, ld1;
  logic [tsd_pkg::V_W-1:0]     hi60;
  logic [63:0]                 prod3;
  logic [5:0]                  lo0;
  logic [6:0]                  hi_low0;
  logic [tsd_pkg::H100_W-1:0]  h100_0;
  logic                        hi_lt10_0;
  tsd_pkg::tsd_flags_t         flags0;
  logic [tsd_pkg::H100_W+6:0]  h100x100;
  logic [6:0]                  hm;
  logic [14:0]                 hm_div;
  logic [14:0]                 lo_div;
  logic [tsd_pkg::DIG_W-1:0]   th, tn;
  logic [6:0]                  th10;
  logic [5:0]                  tn10;
  tsd_pkg::tsd_dig_t           dig1;

  assign ld1      = !vld1 || out_ready;
  assign ld0      = !vld0 || ld1;
  assign in_ready = ld0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld0 <= 1'b0;
      vld1 <= 1'b0;
    end else begin
      if (ld0) vld0 <= in_valid;
      if (ld1) vld1 <= vld0;
    end
  end

  // low part v - hi*60 lies in 0..59, so six bits of the difference suffice
  assign hi60  = {in_quot.hi, 6'd0} - {4'd0, in_quot.hi, 2'd0};
  assign prod3 = {44'd0, in_quot.hi} * {32'd0, tsd_pkg::DIV100_MAGIC};

  always_ff @(posedge clk) begin
    if (ld0) begin
      lo0       <= in_quot.v[5:0] - hi60[5:0];
      hi_low0   <= in_quot.hi[6:0];
      h100_0    <= prod3[tsd_pkg::MAGIC_SHIFT +: tsd_pkg::H100_W];
      hi_lt10_0 <= in_quot.hi < tsd_pkg::MINUS_LIMIT;
      flags0    <= in_quot.flags;
    end
  end

  // hi mod 100, low seven bits are exact since the result is below 100
  assign h100x100 = {1'b0, h100_0, 6'd0} + {2'd0, h100_0, 5'd0} + {5'd0, h100_0, 2'd0};
  assign hm       = hi_low0 - h100x100[6:0];

  // split each two-digit value by a reciprocal of ten
  assign hm_div = {8'd0, hm} * {7'd0, tsd_pkg::DIV10_MAGIC};
  assign lo_div = {9'd0, lo0} * {7'd0, tsd_pkg::DIV10_MAGIC};
  assign th     = hm_div[tsd_pkg::DIV10_SHIFT +: tsd_pkg::DIG_W];
  assign tn     = lo_div[tsd_pkg::DIV10_SHIFT +: tsd_pkg::DIG_W];
  assign th10   = {th, 3'd0} + {2'd0, th, 1'b0};
  assign tn10   = {tn[2:0], 3'd0} + {1'b0, tn, 1'b0};

  always_ff @(posedge clk) begin
    if (ld1) begin
      dig1.thousands <= th;
      dig1.hundreds  <= 4'(hm - th10);
      dig1.tens      <= tn;
      dig1.ones      <= 4'(lo0 - tn10);
      dig1.hi_lt10   <= hi_lt10_0;
      dig1.flags     <= flags0;
    end
  end

  assign out_valid = vld1;
  assign out_dig   = dig1;

endmodule

`default_nettype wire

FILE: rtl/tsd_seg.sv
// tsd_seg: leading zero blanking, segment lookup, dot and minus flags, and
// the output register. Uses tsd_pkg for types and the segment table.
`default_nettype none

module tsd_seg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              show_leading_zeros,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire tsd_pkg::tsd_dig_t in_dig,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [31:0]            m_tdata
);

  logic                      ld;
  logic                      show_th;
  logic [tsd_pkg::SEG_W-1:0] seg_th;
  logic                      lower, upper, minus;

  assign ld       = !m_tvalid || m_tready;
  assign in_ready = ld;

  // only the leftmost digit can be blanked, three digits always show
  assign show_th = show_leading_zeros || (in_dig.thousands != 4'd0);
  assign seg_th  = show_th ? tsd_pkg::seg7(in_dig.thousands) : 7'd0;

  // separator dots and minus bar
  always_comb begin
    if (in_dig.flags.neg) begin
      lower = in_dig.flags.phase;
      upper = !in_dig.flags.phase;
      minus = in_dig.hi_lt10;
    end else begin
      lower = 1'b1;
      upper = in_dig.flags.big;
      minus = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ld) begin
      m_tvalid <= in_valid;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (ld) begin
      m_tdata <= {1'b0, minus, upper, lower,
                  tsd_pkg::seg7(in_dig.ones),
                  tsd_pkg::seg7(in_dig.tens),
                  tsd_pkg::seg7(in_dig.hundreds),
                  seg_th};
    end
  end

endmodule

`default_nettype wire
